### hw/rtl/urrg_pkg.sv
// ----------------------------------------------------------------------------
// urrg_pkg
// Shared constants, opcodes and divider interface types for the uniform
// range random generator.
// ----------------------------------------------------------------------------
package urrg_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int SEED_ROUNDS     = 10;
   localparam int RES_W           = 24;
   localparam int DIV_W           = 29;
   localparam int BOUND_W         = 25;

   localparam logic [31:0]        LCG_MUL   = 32'd1103515245;
   localparam logic [31:0]        LCG_ADD   = 32'd12345;
   localparam logic [DIV_W-1:0]   SPAN_28   = 29'h1000_0000;
   localparam logic [BOUND_W-1:0] BOUND_MAX = 25'h100_0000;

   typedef enum logic [1:0] {
      OP_DRAW = 2'd0,
      OP_SEED = 2'd1,
      OP_LOAD = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

### hw/rtl/urrg_ram.sv
// ----------------------------------------------------------------------------
// urrg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module urrg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### hw/rtl/urrg_div.sv
// ----------------------------------------------------------------------------
// urrg_div
// Iterative restoring divider, one quotient bit per cycle. Shared by the
// partition size calculation and the rejection trials.
// ----------------------------------------------------------------------------
module urrg_div
   import urrg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         // no borrow means the divisor fits into the partial remainder
         if (!diff[DIV_W]) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(DIV_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### hw/rtl/uniform_range_random_generator.sv
// ----------------------------------------------------------------------------
// uniform_range_random_generator
// Bounded random draws from an LCG or an additive table generator, with
// rejection of out-of-range quotients, table seeding and LCG load.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_opcode, req_operand
//  rsp     | out       | rsp_valid/rsp_stall | rsp_value
//  csr     | in        | csr_valid/csr_ready | csr_quick_mode
//
//  One item at a time; req_stall is high from acceptance until the result is
//  loaded into the output register. A draw with a bound above one gets the
//  partition size from the shared divider, then per trial steps the LCG or the
//  table (one RAM read and one write) and divides the word by that size. A seed
//  fills the table and runs SEED_ROUNDS*TABLE_DEPTH table steps. Load sets the LCG.
//  Reset is synchronous; a stalled result holds and the next item waits.
// ----------------------------------------------------------------------------
module uniform_range_random_generator
   import urrg_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_opcode,
   input  logic [31:0]      req_operand,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [RES_W-1:0] rsp_value,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_quick_mode
);

   localparam int PW         = $clog2(TABLE_DEPTH);
   localparam int STEP_TOTAL = SEED_ROUNDS * TABLE_DEPTH;
   localparam int SW         = $clog2(STEP_TOTAL);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_SEED_RD,
      S_SEED_CAP,
      S_STEP_RD,
      S_STEP_WR,
      S_GEN,
      S_DIV_GO,
      S_DIV_WAIT,
      S_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]   rsp_value_ff, rsp_value_in;
   logic               quick_ff, quick_in;
   logic [31:0]        lcg_ff, lcg_in;
   logic [PW-1:0]      pos_ff, pos_in;
   opcode_type         op_ff, op_in;
   logic [BOUND_W-1:0] bound_ff, bound_in;
   logic               have_n_ff, have_n_in;
   logic [DIV_W-1:0]   n_ff, n_in;
   logic [31:0]        word_ff, word_in;
   logic [31:0]        cur_ff, cur_in;
   logic [31:0]        fill_ff, fill_in;
   logic [PW-1:0]      idx_ff, idx_in;
   logic [SW-1:0]      cnt_ff, cnt_in;
   logic [RES_W-1:0]   res_ff, res_in;

   logic [PW-1:0]      nxt_pos;
   logic [31:0]        mul_src;
   logic [31:0]        mul_out;
   logic [31:0]        step_sum;
   logic               ram_wr_en;
   logic [PW-1:0]      ram_wr_addr;
   logic [31:0]        ram_wr_data;
   logic               ram_rd_en;
   logic [PW-1:0]      ram_rd_addr;
   logic [31:0]        ram_rd_data;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   urrg_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   urrg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign nxt_pos  = (pos_ff == PW'(TABLE_DEPTH-1)) ? '0 : pos_ff + 1'b1;
   // one multiplier serves both the table fill and the quick generator
   assign mul_src  = (state_ff == S_FILL) ? fill_ff : lcg_ff;
   assign mul_out  = mul_src * LCG_MUL + LCG_ADD;
   assign step_sum = cur_ff + ram_rd_data;

   assign ram_wr_en   = (state_ff == S_FILL) || (state_ff == S_STEP_WR);
   assign ram_wr_addr = (state_ff == S_FILL) ? idx_ff : nxt_pos;
   assign ram_wr_data = (state_ff == S_FILL) ? fill_ff : step_sum;
   assign ram_rd_en   = (state_ff == S_STEP_RD) || (state_ff == S_SEED_RD);
   assign ram_rd_addr = (state_ff == S_SEED_RD) ? pos_ff : nxt_pos;

   assign div_req.start    = (state_ff == S_DIV_GO);
   assign div_req.dividend = have_n_ff ? {1'b0, word_ff[31:4]} : SPAN_28;
   assign div_req.divisor  = have_n_ff ? n_ff : DIV_W'(bound_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      quick_in     = quick_ff;
      lcg_in       = lcg_ff;
      pos_in       = pos_ff;
      op_in        = op_ff;
      bound_in     = bound_ff;
      have_n_in    = have_n_ff;
      n_in         = n_ff;
      word_in      = word_ff;
      cur_in       = cur_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;

      if (csr_valid) begin
         quick_in = csr_quick_mode;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in  = opcode_type'(req_opcode);
               res_in = '0;
               case (opcode_type'(req_opcode))
                  OP_DRAW: begin
                     if (req_operand <= 32'd1) begin
                        bound_in = BOUND_W'(1);
                        state_in = S_FINISH;
                     end else begin
                        bound_in  = (req_operand > 32'(BOUND_MAX)) ? BOUND_MAX
                                                                  : req_operand[BOUND_W-1:0];
                        have_n_in = 1'b0;
                        state_in  = S_DIV_GO;
                     end
                  end
                  OP_SEED: begin
                     fill_in  = req_operand;
                     idx_in   = '0;
                     state_in = S_FILL;
                  end
                  OP_LOAD: begin
                     lcg_in   = req_operand;
                     state_in = S_FINISH;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_FILL: begin
            fill_in = mul_out;
            if (idx_ff == PW'(TABLE_DEPTH-1)) begin
               cnt_in   = '0;
               state_in = S_SEED_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SEED_RD: begin
            state_in = S_SEED_CAP;
         end
         S_SEED_CAP: begin
            cur_in   = ram_rd_data;
            state_in = S_STEP_RD;
         end
         S_STEP_RD: begin
            state_in = S_STEP_WR;
         end
         S_STEP_WR: begin
            cur_in  = step_sum;
            word_in = step_sum;
            pos_in  = nxt_pos;
            if (op_ff == OP_SEED) begin
               if (cnt_ff == SW'(STEP_TOTAL-1)) begin
                  state_in = S_FINISH;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_STEP_RD;
               end
            end else begin
               state_in = S_DIV_GO;
            end
         end
         S_GEN: begin
            if (quick_ff) begin
               lcg_in   = mul_out;
               word_in  = mul_out;
               state_in = S_DIV_GO;
            end else begin
               state_in = S_STEP_RD;
            end
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (!have_n_ff) begin
                  n_in      = div_rsp.quotient;
                  have_n_in = 1'b1;
                  state_in  = S_GEN;
               end else if (div_rsp.quotient < DIV_W'(bound_ff)) begin
                  res_in   = div_rsp.quotient[RES_W-1:0];
                  state_in = S_FINISH;
               end else begin
                  // rejected trial, step the generator again
                  state_in = S_GEN;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         quick_ff     <= 1'b1;
         lcg_ff       <= '0;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         quick_ff     <= quick_in;
         lcg_ff       <= lcg_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      op_ff        <= op_in;
      bound_ff     <= bound_in;
      have_n_ff    <= have_n_in;
      n_ff         <= n_in;
      word_ff      <= word_in;
      cur_ff       <= cur_in;
      fill_ff      <= fill_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      res_ff       <= res_in;
   end

   a_draw_below_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && op_ff == OP_DRAW) |-> (BOUND_W'(res_ff) < bound_ff))
      else $error("drawn value not below bound");

   a_pos_moves_on_step : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_STEP_WR) |=> (pos_ff == $past(pos_ff)))
      else $error("table position moved outside a table step");

   a_div_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_WAIT))
      else $error("divider finished while sequencer not waiting");

   a_idle_no_div_start : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_req.start)
      else $error("divider started while idle");

endmodule
